[hdl/sfh32_pkg.sv]
// Package with the item types, queue sizing and round functions of the hash core.
`timescale 1ns / 1ps
package sfh32_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    RND_FULL,
    RND_TAIL3,
    RND_TAIL2,
    RND_TAIL1,
    RND_NONE
  } sfh_round_e;

  typedef struct packed {
    logic        start;
    logic        last;
    sfh_round_e  kind;
    logic [31:0] length;
    logic [31:0] word;
  } sfh_item_t;

  function automatic logic [31:0] full_round(logic [31:0] h_in, logic [31:0] w);
    logic [31:0] h;
    logic [31:0] t;
    h = h_in + {16'b0, w[15:0]};
    t = {5'b0, w[31:16], 11'b0} ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic logic [31:0] tail_round(logic [31:0] h_in, logic [31:0] w,
                                             sfh_round_e kind);
    logic [31:0] h;
    h = h_in;
    case (kind)
      RND_TAIL3: begin
        h = h + {16'b0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ {6'b0, w[23:16], 18'b0};
        h = h + (h >> 11);
      end
      RND_TAIL2: begin
        h = h + {16'b0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      RND_TAIL1: begin
        h = h + {24'b0, w[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      RND_FULL: h = full_round(h_in, w);
      default:  h = h_in;
    endcase
    return h;
  endfunction

  // The avalanche is split into three pairs of shift steps, one pair per stage.
  function automatic logic [31:0] aval_a(logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    return h;
  endfunction

  function automatic logic [31:0] aval_b(logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 4);
    h = h + (h >> 17);
    return h;
  endfunction

  function automatic logic [31:0] aval_c(logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

[hdl/sfh32_front.sv]
// Front end: takes input items and classifies the round each one needs.
`timescale 1ns / 1ps
module sfh32_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 start_of_message_i,
  input  logic [31:0]          message_length_i,
  input  logic [31:0]          data_word_i,
  input  logic [2:0]           byte_count_i,
  input  logic                 end_of_message_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sfh32_pkg::sfh_item_t q_item_o
);
  import sfh32_pkg::*;

  sfh_round_e kind;

  always_comb begin
    if (!end_of_message_i) begin
      kind = RND_FULL;
    end else begin
      case (byte_count_i)
        3'd0:    kind = RND_NONE;
        3'd1:    kind = RND_TAIL1;
        3'd2:    kind = RND_TAIL2;
        3'd3:    kind = RND_TAIL3;
        default: kind = RND_FULL;
      endcase
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.start  = start_of_message_i;
    q_item_o.last   = end_of_message_i;
    q_item_o.kind   = kind;
    q_item_o.length = message_length_i;
    q_item_o.word   = data_word_i;
  end

endmodule

[hdl/sfh32_fifo.sv]
// Short item queue between the front end and the hash engine.
`timescale 1ns / 1ps
module sfh32_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfh32_pkg::sfh_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output sfh32_pkg::sfh_item_t item_o,
  output logic                 empty_o
);
  import sfh32_pkg::*;

  sfh_item_t          mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/sfh32_back.sv]
// Hash engine: accumulator rounds, pipelined avalanche and the result register.
`timescale 1ns / 1ps
module sfh32_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfh32_pkg::sfh_item_t item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          hash_value_o
);
  import sfh32_pkg::*;

  logic [31:0] acc_q, acc_d;
  logic [31:0] seed;
  logic [31:0] round_h;
  logic        adv;
  logic        v0_q, v1_q, v2_q, vout_q;
  logic [31:0] h0_q, h1_q, h2_q, hout_q;

  // The whole avalanche pipeline moves together whenever the result slot is free.
  assign adv   = !vout_q || !out_stall_i;
  // Items that are not last only touch the accumulator, so they may drain during a stall.
  assign pop_o = !empty_i && (!item_i.last || adv);

  assign seed    = item_i.start ? item_i.length : acc_q;
  assign round_h = tail_round(seed, item_i.word, item_i.kind);

  always_comb begin
    acc_d = acc_q;
    if (pop_o) begin
      acc_d = item_i.last ? 32'd0 : round_h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (adv) begin
        v0_q   <= pop_o && item_i.last;
        v1_q   <= v0_q;
        v2_q   <= v1_q;
        vout_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h0_q   <= round_h;
      h1_q   <= aval_a(h0_q);
      h2_q   <= aval_b(h1_q);
      hout_q <= aval_c(h2_q);
    end
  end

  assign out_valid_o  = vout_q;
  assign hash_value_o = hout_q;

endmodule

[hdl/super_fast_hash_32_core.sv]
// Top level of the 32-bit SuperFastHash core.
`timescale 1ns / 1ps
// The core takes one message word per cycle while in_stall_o is low, and gives one hash
// per message, on the item that carries end_of_message. Sustained rate is one item per
// clock when nothing stalls; it is set by the accumulator round in the hash engine, which
// must finish before the next word of the same message is mixed in. A four-entry queue
// separates the input side from the engine, and the avalanche runs in three further
// stages after the round register. While the result waits, words of the following
// message keep flowing into the accumulator.
module super_fast_hash_32_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_of_message_i,
  input  logic [31:0] message_length_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);
  import sfh32_pkg::*;

  sfh_item_t push_item;
  sfh_item_t pop_item;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  sfh32_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .start_of_message_i (start_of_message_i),
    .message_length_i   (message_length_i),
    .data_word_i        (data_word_i),
    .byte_count_i       (byte_count_i),
    .end_of_message_i   (end_of_message_i),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_item_o           (push_item)
  );

  sfh32_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .empty_o (q_empty)
  );

  sfh32_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pop_item),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the 32-bit SuperFastHash core, with its own hash predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned ItemTarget = 1900;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  typedef struct {
    logic        start;
    logic [31:0] length;
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    bit          known;
    logic [31:0] golden;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        start_of_message_i = 1'b0;
  logic [31:0] message_length_i = 32'h0;
  logic [31:0] data_word_i = 32'h0;
  logic [2:0]  byte_count_i = 3'd0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] hash_value_o;

  logic [31:0] hash_acc = 32'h0;
  logic        msg_open = 1'b0;
  logic [31:0] pending_hashes[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  super_fast_hash_32_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .start_of_message_i (start_of_message_i),
    .message_length_i   (message_length_i),
    .data_word_i        (data_word_i),
    .byte_count_i       (byte_count_i),
    .end_of_message_i   (end_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hash_value_o       (hash_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [31:0] mix_word(logic [31:0] h_in, logic [31:0] w);
    logic [31:0] h;
    logic [31:0] t;
    h = h_in + {16'b0, w[15:0]};
    t = ({16'b0, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic logic [31:0] mix_tail(logic [31:0] h_in, logic [31:0] w,
                                           logic [2:0] n);
    logic [31:0] h;
    h = h_in;
    if (n == 3'd3) begin
      h = h + {16'b0, w[15:0]};
      h = h ^ (h << 16);
      h = h ^ ({24'b0, w[23:16]} << 18);
      h = h + (h >> 11);
    end else if (n == 3'd2) begin
      h = h + {16'b0, w[15:0]};
      h = h ^ (h << 11);
      h = h + (h >> 17);
    end else if (n == 3'd1) begin
      h = h + {24'b0, w[7:0]};
      h = h ^ (h << 10);
      h = h + (h >> 1);
    end
    return h;
  endfunction

  function automatic logic [31:0] avalanche_mix(logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  // Advances the predicted state by one item; returns 1 when the item closes a message.
  function automatic bit predict_hash(logic start, logic [31:0] length, logic [31:0] word,
                                      logic [2:0] count, logic last,
                                      output logic [31:0] hash);
    logic [31:0] h;
    if (start) begin
      hash_acc = length;
      msg_open = 1'b1;
    end
    h = hash_acc;
    hash = 32'h0;
    if (!last) begin
      hash_acc = mix_word(h, word);
      return 1'b0;
    end
    if (count >= 3'd4) h = mix_word(h, word);
    else h = mix_tail(h, word, count);
    hash = avalanche_mix(h);
    hash_acc = 32'h0;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t make_row(logic start, logic [31:0] length, logic [31:0] word,
                                         logic [2:0] count, logic last, bit known,
                                         logic [31:0] golden);
    stim_row_t r;
    r.start = start;
    r.length = length;
    r.word = word;
    r.count = count;
    r.last = last;
    r.known = known;
    r.golden = golden;
    return r;
  endfunction

  // Called just after a rising edge; returns just after the edge that takes the item.
  task automatic send_item(logic start, logic [31:0] length, logic [31:0] word,
                           logic [2:0] count, logic last, bit known, logic [31:0] golden);
    int unsigned gap;
    logic [31:0] hash;
    if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_of_message_i <= start;
    message_length_i <= length;
    data_word_i <= word;
    byte_count_i <= count;
    end_of_message_i <= last;
    if (predict_hash(start, length, word, count, last, hash))
      pending_hashes.push_back(known ? golden : hash);
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_message(bit with_start);
    int unsigned n_words;
    int unsigned tail;
    logic [31:0] length;
    logic [2:0]  count;
    n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    tail = $urandom_range(0, 4);
    length = 4 * (n_words - 1) + tail;
    if ($urandom_range(0, 7) == 0) length = $urandom;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (i == n_words - 1) count = tail[2:0];
      else count = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_item(with_start && (i == 0), length, $urandom, count, i == n_words - 1, 1'b0,
                32'h0);
    end
  endtask

  // Result side: checks each taken hash and then holds off for a random number of cycles.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, hash_value_o);
        mismatch_count++;
      end else begin
        if (hash_value_o !== pending_hashes[0]) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h", $time,
                   pending_hashes[0], hash_value_o);
          mismatch_count++;
        end
        void'(pending_hashes.pop_front());
      end
      if ($urandom_range(0, 29) == 0) take_calm = ~take_calm;
      hold_left = take_calm ? 0 : $urandom_range(0, 6);
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    // An empty message seeded with zero avalanches zero, which stays zero.
    directed_rows.push_back(make_row(1, 32'h0, 32'h0, 3'd0, 1, 1, 32'h0));
    directed_rows.push_back(make_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'h0, 32'h0, 3'd4, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd7, 32'h0403_0201, 3'd4, 0, 0, 0));
    directed_rows.push_back(make_row(0, 32'h0, 32'h0007_0605, 3'd3, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd6, 32'h1122_3344, 3'd4, 0, 0, 0));
    directed_rows.push_back(make_row(0, 32'h0, 32'hFFFF_5566, 3'd2, 1, 0, 0));
    // The count on a word that is not last is ignored.
    directed_rows.push_back(make_row(1, 32'd5, 32'hDEAD_BEEF, 3'd0, 0, 0, 0));
    directed_rows.push_back(make_row(0, 32'h0, 32'hFFFF_FFAB, 3'd1, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd4, 32'h89AB_CDEF, 3'd5, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd4, 32'h89AB_CDEF, 3'd6, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd4, 32'h89AB_CDEF, 3'd7, 1, 0, 0));
    // Words without a start after a closed message mix into a zero accumulator.
    directed_rows.push_back(make_row(0, 32'h1234_5678, 32'hCAFE_F00D, 3'd4, 0, 0, 0));
    directed_rows.push_back(make_row(0, 32'h0, 32'h0BAD_F00D, 3'd4, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd100, 32'h0102_0304, 3'd4, 0, 0, 0));
    directed_rows.push_back(make_row(1, 32'd8, 32'h0506_0708, 3'd4, 0, 0, 0));
    directed_rows.push_back(make_row(0, 32'h0, 32'h090A_0B0C, 3'd4, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'hFFFF_FFFF, 32'h00FF_FFFF, 3'd3, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'd4, 32'hFFFF_FFFF, 3'd4, 0, 0, 0));
    directed_rows.push_back(make_row(0, 32'h0, 32'h1234_5678, 3'd0, 1, 0, 0));
    directed_rows.push_back(make_row(1, 32'h0, 32'hFFFF_FFFF, 3'd1, 1, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].start, directed_rows[i].length, directed_rows[i].word,
                directed_rows[i].count, directed_rows[i].last, directed_rows[i].known,
                directed_rows[i].golden);

    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        8: begin
          // Broken sequences: start and end bits and counts drawn freely.
          repeat ($urandom_range(1, 3))
            send_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                      3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0, 32'h0);
        end
        9: send_message(1'b0);
        default: send_message(1'b1);
      endcase
    end
    in_valid_i <= 1'b0;

    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_hashes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[super_fast_hash_32_core.f]
hdl/sfh32_pkg.sv
hdl/sfh32_front.sv
hdl/sfh32_fifo.sv
hdl/sfh32_back.sv
hdl/super_fast_hash_32_core.sv
test/testbench.sv
